// File: sv/cnfc_pkg.sv
`default_nettype none
package cnfc_pkg;
    localparam int MaxClone1 = 16;
    localparam int MaxClone2 = 4;
    localparam int B1W = $clog2(MaxClone1 + 1);
    localparam int B2W = $clog2(MaxClone2 + 1);
    localparam logic [47:0] CostMax = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] RegNormal = 2'd0;
    localparam logic [1:0] RegTumor1 = 2'd1;
    localparam logic [1:0] RegTumor2 = 2'd2;
    localparam logic [1:0] RegDisp   = 2'd3;

    typedef struct packed {
        logic [23:0] seg_mean;
        logic [23:0] seg_var;
        logic [15:0] allele_rate;
        logic        last_segment;
    } in_word_t;

    typedef struct packed {
        logic        skipped;
        logic [47:0] best_cost;
        logic [3:0]  clone1_minor;
        logic [4:0]  clone1_major;
        logic [1:0]  clone2_minor;
        logic [2:0]  clone2_major;
        logic [47:0] cost_total;
        logic        is_last;
    } out_word_t;

    // classified segment passed from front to back
    typedef struct packed {
        logic        skip;
        logic        last;
        logic [23:0] mean;
        logic [23:0] hmin;
        logic [23:0] hmaj;
    } job_t;

    typedef struct packed {
        logic [12:0] n;
        logic [13:0] f1;
        logic [13:0] f2;
        logic [9:0]  disp;
    } cfg_t;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? CostMax : s[47:0];
    endfunction
endpackage
`default_nettype wire

// File: sv/cnfc_if.sv
`default_nettype none
interface cnfc_in_if;
    import cnfc_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cnfc_out_if;
    import cnfc_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/cnfc_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned
module cnfc_divider
    import cnfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [57:0] num,
    input  wire logic [23:0] den,
    output logic             done,
    output logic [57:0]      quo
);
    logic [57:0] q_reg, q_next;
    logic [24:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] sh;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh        = {r_reg[23:0], q_reg[57]};
        done      = 1'b0;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = 6'd58;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den})
            begin
                r_next = sh - {1'b0, den};
                q_next = {q_reg[56:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[56:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quo = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule
`default_nettype wire

// File: sv/cnfc_front.sv
`default_nettype none
// skip test and haplotype targets, one registered stage
module cnfc_front
    import cnfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    cnfc_in_if.sink    in_ch,
    output logic       job_valid,
    input  wire logic  job_ready,
    output job_t       job
);
    logic        v_reg;
    job_t        job_reg;
    logic [33:0] lhs, rhs;
    logic [16:0] r_adj;
    logic [16:0] r_inc;
    logic [40:0] pmin, pmaj;
    logic [23:0] m;

    assign m = in_ch.data.seg_mean;
    assign in_ch.ready = !v_reg || job_ready;
    assign job_valid = v_reg;
    assign job = job_reg;

    always_comb
    begin
        lhs   = {2'b0, in_ch.data.seg_var, 8'd0};
        rhs   = 34'(cfg.disp) * 34'(m);
        r_inc = {1'b0, in_ch.data.allele_rate} + 17'd655;
        r_adj = {1'b0, in_ch.data.allele_rate};
        if (in_ch.data.allele_rate > 16'd28180)
            r_adj = (r_inc > 17'd32768) ? 17'd32768 : r_inc;
        pmin = 41'(m) * 41'(r_adj) + 41'd32768;
        pmaj = 41'(m) * 41'(17'h10000 - r_adj) + 41'd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ch.ready)
            v_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            job_reg.skip <= (m == 24'd0) || (lhs > rhs);
            job_reg.last <= in_ch.data.last_segment;
            job_reg.mean <= m;
            job_reg.hmin <= pmin[39:16];
            job_reg.hmaj <= pmaj[39:16];
        end
    end
endmodule
`default_nettype wire

// File: sv/cnfc_queue.sv
`default_nettype none
// two-entry queue between front and back
module cnfc_queue
    import cnfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire job_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// File: sv/cnfc_back.sv
`default_nettype none
// copy-count search sequencer, one serial divide per scored candidate
module cnfc_back
    import cnfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    cnfc_out_if.source out_ch
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_B1    = 9'b000000010,
        S_B1W   = 9'b000000100,
        S_B2    = 9'b000001000,
        S_B2W   = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_DIVW  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    job_t   j_reg;
    logic signed [25:0] base_reg;
    logic [B1W-1:0] b1_reg, a1_reg, c1_reg;
    logic [B2W-1:0] b2_reg, a2_reg, c2_reg;
    logic [47:0] best_reg, run_reg;
    logic        found_reg;
    logic [3:0]  w1_reg;
    logic [4:0]  x1_reg;
    logic [1:0]  w2_reg;
    logic [2:0]  x2_reg;
    logic [49:0] sum_reg;
    logic        neg_reg;
    logic        ov_valid_reg;
    out_word_t   ov_reg;

    logic        div_start, div_done;
    logic [57:0] div_num, div_quo;
    logic [23:0] div_den;

    cnfc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic [B1W:0]   s1;
    logic [B2W:0]   s2;
    logic signed [33:0] t1, t2, d0, d1, d2, num2;
    logic [33:0] ad0, ad1, ad2;
    logic signed [33:0] bq2;
    logic [47:0] cost, cost_a;
    logic        skip_combo;
    logic        last_c1, last_a1, last_c2, last_a2;

    always_comb
    begin
        s1 = (B1W+1)'(a1_reg) + (B1W+1)'(c1_reg);
        s2 = (B2W+1)'(a2_reg) + (B2W+1)'(c2_reg);
        num2 = 34'(base_reg) - 34'(cfg.f1) * 34'(s1);
        t1 = 34'(a2_reg) * 34'(cfg.f2) + 34'(a1_reg) * 34'(cfg.f1) + 34'(cfg.n);
        t2 = 34'(c2_reg) * 34'(cfg.f2) + 34'(c1_reg) * 34'(cfg.f1) + 34'(cfg.n);
        d0 = 34'(s2) * 34'(cfg.f2) + 34'(s1) * 34'(cfg.f1) + 34'(cfg.n) * 34'd2
             - 34'(j_reg.mean);
        d1 = 34'(j_reg.hmin) - t1;
        d2 = 34'(j_reg.hmaj) - t2;
        ad0 = d0[33] ? -d0 : d0;
        ad1 = d1[33] ? -d1 : d1;
        ad2 = d2[33] ? -d2 : d2;
        skip_combo = (b2_reg != '0) && (5'(a2_reg) != 5'(a1_reg))
                     && (5'(c2_reg) != 5'(c1_reg));
        // bound quotients fit in 26 bits: numerators below 2^25, divisor >= 1
        bq2 = neg_reg ? -34'(div_quo[25:0]) : 34'(div_quo[25:0]);
        cost = (div_quo[57:48] != '0) ? CostMax : div_quo[47:0];
        cost_a = cost;
        if (s1 >= 5 || s2 >= 5)
            cost_a = sat_add(cost_a, 48'h30000);
        else if (s1 >= 4 || s2 >= 4)
            cost_a = sat_add(cost_a, 48'h10000);
        if (b2_reg != '0 && 6'(s2) != 6'(s1))
            cost_a = sat_add(cost_a, 48'd98304);
        last_c2 = 5'(c2_reg) >= 5'(b2_reg) - 5'(a2_reg);
        last_a2 = 5'(a2_reg) + 5'd1 > 5'(b2_reg >> 1);
        last_c1 = 8'(c1_reg) >= 8'(b1_reg) - 8'(a1_reg);
        last_a1 = 8'(a1_reg) + 8'd1 > 8'(b1_reg >> 1);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 24'(cfg.f1);
        unique case (state_reg)
            S_B1:
            begin
                div_start = cfg.f1 != '0;
                div_num   = 58'(base_reg[25] ? -base_reg : base_reg);
            end
            S_B2:
            begin
                div_start = cfg.f2 != '0;
                div_den   = 24'(cfg.f2);
                div_num   = 58'(num2[33] ? -num2 : num2);
            end
            S_DIV:
            begin
                div_start = 1'b1;
                div_den   = j_reg.mean;
                div_num   = {sum_reg, 8'd0};
            end
            S_B1W, S_B2W, S_DIVW:
            begin
                div_den = (state_reg == S_DIVW) ? j_reg.mean
                        : (state_reg == S_B2W) ? 24'(cfg.f2) : 24'(cfg.f1);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign job_ready = state_reg == S_IDLE && !ov_valid_reg;
    assign out_ch.valid = ov_valid_reg;
    assign out_ch.data  = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (job_valid && job_ready)
                state_next = job.skip ? S_OUT : S_B1;
            S_B1: state_next = (cfg.f1 != '0) ? S_B1W : S_B2;
            S_B1W: if (div_done) state_next = S_B2;
            S_B2: state_next = (cfg.f2 != '0) ? S_B2W : S_SQ;
            S_B2W: if (div_done) state_next = S_SQ;
            S_SQ: state_next = skip_combo ? S_DIVW : S_DIV;
            S_DIV: state_next = S_DIVW;
            S_DIVW: if (skip_combo || div_done)
            begin
                if (!last_c2 || !last_a2)
                    state_next = S_SQ;
                else if (!last_c1 || !last_a1)
                    state_next = S_B2;
                else
                    state_next = S_OUT;
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [34:0] b1_raw;
    logic signed [34:0] b2_raw;
    always_comb
    begin
        b1_raw = 35'(bq2) + 35'sd2;
        b2_raw = 35'(bq2) + 35'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_valid_reg <= 1'b0;
            run_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT)
            begin
                ov_valid_reg <= 1'b1;
                run_reg <= j_reg.last ? '0
                         : (j_reg.skip ? run_reg : sat_add(run_reg, best_reg));
            end
            else if (out_ch.valid && out_ch.ready)
                ov_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                j_reg     <= job;
                base_reg  <= 26'(job.mean) - 26'(cfg.n) * 26'd2;
                found_reg <= 1'b0;
                best_reg  <= '0;
                w1_reg <= '0; x1_reg <= '0; w2_reg <= '0; x2_reg <= '0;
                a1_reg <= '0;
                c1_reg <= '0;
            end
            S_B1:
            begin
                neg_reg <= base_reg[25];
                if (cfg.f1 == '0)
                    b1_reg <= B1W'(MaxClone1);
            end
            S_B1W: if (div_done)
            begin
                if (b1_raw < 0)
                    b1_reg <= '0;
                else if (b1_raw > 35'(MaxClone1))
                    b1_reg <= B1W'(MaxClone1);
                else
                    b1_reg <= B1W'(b1_raw);
            end
            S_B2:
            begin
                neg_reg <= num2[33];
                a2_reg  <= '0;
                c2_reg  <= '0;
                if (cfg.f2 == '0)
                    b2_reg <= '0;
            end
            S_B2W: if (div_done)
            begin
                if (b2_raw < 0)
                    b2_reg <= '0;
                else if (b2_raw > 35'(MaxClone2))
                    b2_reg <= B2W'(MaxClone2);
                else
                    b2_reg <= B2W'(b2_raw);
            end
            S_SQ:
            begin
                sum_reg <= 50'(ad0[24:0]) * 50'(ad0[24:0])
                         + 50'(ad1[24:0]) * 50'(ad1[24:0])
                         + 50'(ad2[24:0]) * 50'(ad2[24:0]);
            end
            S_DIVW: if (skip_combo || div_done)
            begin
                if (!skip_combo && (!found_reg || cost_a < best_reg))
                begin
                    found_reg <= 1'b1;
                    best_reg  <= cost_a;
                    w1_reg <= 4'(a1_reg);
                    x1_reg <= 5'(c1_reg);
                    w2_reg <= 2'(a2_reg);
                    x2_reg <= 3'(c2_reg);
                end
                if (!last_c2)
                    c2_reg <= c2_reg + 1'b1;
                else if (!last_a2)
                begin
                    a2_reg <= a2_reg + 1'b1;
                    c2_reg <= a2_reg + 1'b1;
                end
                else if (!last_c1)
                    c1_reg <= c1_reg + 1'b1;
                else if (!last_a1)
                begin
                    a1_reg <= a1_reg + 1'b1;
                    c1_reg <= a1_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                ov_reg.skipped      <= j_reg.skip;
                ov_reg.best_cost    <= j_reg.skip ? '0 : best_reg;
                ov_reg.clone1_minor <= j_reg.skip ? '0 : w1_reg;
                ov_reg.clone1_major <= j_reg.skip ? '0 : x1_reg;
                ov_reg.clone2_minor <= j_reg.skip ? '0 : w2_reg;
                ov_reg.clone2_major <= j_reg.skip ? '0 : x2_reg;
                ov_reg.cost_total   <= j_reg.skip ? run_reg : sat_add(run_reg, best_reg);
                ov_reg.is_last      <= j_reg.last;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/copy_number_fit_cost_core.sv
`default_nettype none
// Copy-number fit cost. One result word per segment word, in order. A front stage
// classifies each segment into a registered job; a two-word queue feeds the back
// end, which walks the copy-count combinations one at a time with a serial
// divider. Per segment: a divide for the first-clone bound (none if its coverage
// is zero), then per first-clone pair a divide for the second-clone bound (none
// if the second clone is off), a divide per scored combination, none per one
// passed over. Defaults: at most 81 first-clone pairs, no second clone. A skipped
// segment goes from idle to the output state. The back end takes no new segment
// while its result word waits. The user must see that registers are written over
// APB only while no segment is in flight; the block does not enforce it.
module copy_number_fit_cost_core
    import cnfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    cnfc_in_if.sink          in_ch,
    cnfc_out_if.source       out_ch
);
    cfg_t cfg_reg;
    logic [1:0] ridx;
    logic       job_valid, job_ready, q_valid, q_ready;
    job_t       job, q_job;

    assign pready = 1'b1;
    assign ridx = paddr[3:2];

    always_comb
    begin
        unique case (ridx)
            RegNormal: prdata = 32'(cfg_reg.n);
            RegTumor1: prdata = 32'(cfg_reg.f1);
            RegTumor2: prdata = 32'(cfg_reg.f2);
            RegDisp:   prdata = 32'(cfg_reg.disp);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n    <= 13'd512;
            cfg_reg.f1   <= 14'd5120;
            cfg_reg.f2   <= 14'd0;
            cfg_reg.disp <= 10'd768;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (ridx)
                RegNormal: cfg_reg.n    <= pwdata[12:0];
                RegTumor1: cfg_reg.f1   <= pwdata[13:0];
                RegTumor2: cfg_reg.f2   <= pwdata[13:0];
                RegDisp:   cfg_reg.disp <= pwdata[9:0];
                default:   cfg_reg.n    <= cfg_reg.n;
            endcase
        end
    end

    cnfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    cnfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_valid),
        .wr_ready (job_ready),
        .wr_data  (job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    cnfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

// File: sv/cnfc_checker.sv
`default_nettype none
module cnfc_checker
    import cnfc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word dropped");
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.skipped |-> out_data.best_cost == '0)
        else $error("skipped word has cost");
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.skipped |-> out_data.cost_total >= out_data.best_cost)
        else $error("total below cost");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.clone1_minor <= out_data.clone1_major)
        else $error("minor above major");
endmodule

bind copy_number_fit_cost_core cnfc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import cnfc_pkg::*;

    localparam longint CycleLimit = 250_000_000;
    localparam longint RateKnee = 28180;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cnfc_in_if  in_ch ();
    cnfc_out_if out_ch ();

    copy_number_fit_cost_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #2 clk = ~clk;

    // local copy of the register file and running total
    logic [12:0] normal_cov;
    logic [13:0] tumor1_cov;
    logic [13:0] tumor2_cov;
    logic [9:0]  disp_cut;
    logic [47:0] total_cost;

    out_word_t pending_words[$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        steady = 1'b0;
    bit        out_hold = 1'b0;
    int        phase_no = 0;

    typedef struct {
        int  mean;
        int  var_q8;
        int  rate;
        bit  last;
        bit  known;
    } seg_row_t;

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {16'd0, a} + b;
        return (s > {16'd0, CostMax}) ? CostMax : s[47:0];
    endfunction

    function automatic out_word_t fit_segment(in_word_t w);
        longint m, v, r, n, f1, f2, base, b1, b2, a1, c1, a2, c2, s1, s2;
        longint d0, d1, d2, hmin, hmaj;
        logic [63:0] sq, cst, best;
        bit found;
        out_word_t o;
        m = w.seg_mean; v = w.seg_var; r = w.allele_rate;
        n = normal_cov; f1 = tumor1_cov; f2 = tumor2_cov;
        o = '0;
        o.is_last = w.last_segment;
        best = '0;
        found = 1'b0;
        if (m == 0 || (v << 8) > longint'(disp_cut) * m) begin
            o.skipped = 1'b1;
            o.cost_total = total_cost;
            if (w.last_segment) total_cost = '0;
            return o;
        end
        if (r > RateKnee) begin
            r = r + 655;
            if (r > 32768) r = 32768;
        end
        hmin = (m * r + 32768) >> 16;
        hmaj = (m * (65536 - r) + 32768) >> 16;
        base = m - 2 * n;
        b1 = (f1 == 0) ? MaxClone1 : base / f1 + 2;
        if (b1 < 0) b1 = 0;
        if (b1 > MaxClone1) b1 = MaxClone1;
        for (a1 = 0; a1 <= b1 / 2; a1++) begin
            for (c1 = a1; c1 <= b1 - a1; c1++) begin
                s1 = a1 + c1;
                b2 = 0;
                if (f2 != 0) begin
                    b2 = (base - f1 * s1) / f2 + 1;
                    if (b2 > MaxClone2) b2 = MaxClone2;
                    if (b2 < 0) b2 = 0;
                end
                for (a2 = 0; a2 <= b2 / 2; a2++) begin
                    for (c2 = a2; c2 <= b2 - a2; c2++) begin
                        s2 = a2 + c2;
                        if (b2 != 0 && a2 != a1 && c2 != c1) continue;
                        d0 = s2 * f2 + s1 * f1 + 2 * n - m;
                        d1 = hmin - (a2 * f2 + a1 * f1 + n);
                        d2 = hmaj - (c2 * f2 + c1 * f1 + n);
                        sq = 64'(d0 * d0) + 64'(d1 * d1) + 64'(d2 * d2);
                        cst = (sq << 8) / 64'(m);
                        if (cst > {16'd0, CostMax}) cst = {16'd0, CostMax};
                        if (s2 >= 5 || s1 >= 5) cst = add_sat(cst[47:0], 64'd196608);
                        else if (s2 >= 4 || s1 >= 4) cst = add_sat(cst[47:0], 64'd65536);
                        if (b2 != 0 && s2 != s1) cst = add_sat(cst[47:0], 64'd98304);
                        if (!found || cst < best) begin
                            found = 1'b1;
                            best = cst;
                            o.clone1_minor = 4'(a1);
                            o.clone1_major = 5'(c1);
                            o.clone2_minor = 2'(a2);
                            o.clone2_major = 3'(c2);
                        end
                    end
                end
            end
        end
        total_cost = add_sat(total_cost, best);
        o.best_cost = best[47:0];
        o.cost_total = total_cost;
        if (w.last_segment) total_cost = '0;
        return o;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !out_hold && (steady || $urandom_range(99, 0) >= 28);
    end

    always @(posedge clk)
    begin
        out_word_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.skipped !== want.skipped || got.best_cost !== want.best_cost ||
                    got.clone1_minor !== want.clone1_minor ||
                    got.clone1_major !== want.clone1_major ||
                    got.clone2_minor !== want.clone2_minor ||
                    got.clone2_major !== want.clone2_major ||
                    got.cost_total !== want.cost_total || got.is_last !== want.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp skip=%0d cost=%h c1=%0d/%0d c2=%0d/%0d tot=%h last=%0d",
                            want.skipped, want.best_cost, want.clone1_minor,
                            want.clone1_major, want.clone2_minor, want.clone2_major,
                            want.cost_total, want.is_last);
                        $display("         got skip=%0d cost=%h c1=%0d/%0d c2=%0d/%0d tot=%h last=%0d",
                            got.skipped, got.best_cost,
                            got.clone1_minor, got.clone1_major, got.clone2_minor,
                            got.clone2_major, got.cost_total, got.is_last);
                    end
                end
            end
        end
    end

    // receiver hold-off while the sender keeps offering words
    initial
    begin
        wait (phase_no == 6);
        @(posedge clk);
        out_hold = 1'b1;
        repeat (200000) @(posedge clk);
        out_hold = 1'b0;
    end

    task automatic reg_write(logic [1:0] idx, int value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegNormal: normal_cov = 13'(value);
            RegTumor1: tumor1_cov = 14'(value);
            RegTumor2: tumor2_cov = 14'(value);
            default:   disp_cut = 10'(value);
        endcase
    endtask

    task automatic drain(int tail);
        while (pending_words.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic send_word(in_word_t w, bit known);
        out_word_t e;
        if (!steady && $urandom_range(99, 0) < 28)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        e = fit_segment(w);
        if (known)
        begin
            e = '0;
            e.skipped = 1'b1;
            e.is_last = w.last_segment;
        end
        pending_words = {pending_words, e};
    endtask

    function automatic in_word_t random_segment(int kmax, int noise_pct);
        in_word_t w;
        longint m, cut;
        w.allele_rate = 16'($urandom_range(65535, 0));
        if ($urandom_range(3, 0) == 0) w.allele_rate = 16'($urandom_range(32768, 24000));
        w.last_segment = ($urandom_range(15, 0) == 0);
        if ($urandom_range(99, 0) < noise_pct)
        begin
            w.seg_mean = 24'($urandom);
            w.seg_var = 24'($urandom);
            return w;
        end
        m = 2 * longint'(normal_cov) + $urandom_range(kmax, 0) * longint'(tumor1_cov)
            + $urandom_range(tumor1_cov + 600, 0) - tumor1_cov / 2;
        if (m < 1) m = $urandom_range(3000, 1);
        if (m > 24'hFFFFFF) m = 24'hFFFFFF;
        w.seg_mean = 24'(m);
        cut = (longint'(disp_cut) * m) >> 8;
        if (cut > 24'hFFFFFF) cut = 24'hFFFFFF;
        if ($urandom_range(9, 0) == 0)
            w.seg_var = 24'(cut + $urandom_range(5000, 1) > 24'hFFFFFF ?
                            24'hFFFFFF : cut + $urandom_range(5000, 1));
        else
            w.seg_var = 24'(longint'($urandom_range(1000, 0)) * cut / 1000);
        return w;
    endfunction

    task automatic run_phase(int n, int f1, int f2, int disp, int count, int kmax, int noise);
        drain(20);
        reg_write(RegNormal, n);
        reg_write(RegTumor1, f1);
        reg_write(RegTumor2, f2);
        reg_write(RegDisp, disp);
        phase_no++;
        for (int i = 0; i < count; i++)
            send_word(random_segment(kmax, noise), 1'b0);
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        seg_row_t rows[$];
        in_word_t w;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        normal_cov = 13'd512;
        tumor1_cov = 14'd5120;
        tumor2_cov = 14'd0;
        disp_cut = 10'd768;
        total_cost = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{0, 0, 0, 0, 1},
            '{0, 16777215, 65535, 1, 1},
            '{1, 16777215, 100, 0, 1},
            '{1024, 0, 0, 0, 0},
            '{6144, 0, 28180, 0, 0},
            '{6144, 0, 28181, 0, 0},
            '{6144, 100, 65535, 1, 0},
            '{7000, 21000, 32113, 0, 0},
            '{7000, 21001, 32768, 0, 0},
            '{16777215, 0, 32768, 0, 0},
            '{16777215, 16777215, 0, 1, 0},
            '{5000, 1000, 12345, 0, 0},
            '{1, 0, 65535, 0, 0},
            '{12000, 5000, 40000, 1, 0},
            '{11264, 30000, 21845, 1, 0}
        };
        foreach (rows[i])
        begin
            w.seg_mean = 24'(rows[i].mean);
            w.seg_var = 24'(rows[i].var_q8);
            w.allele_rate = 16'(rows[i].rate);
            w.last_segment = rows[i].last;
            send_word(w, rows[i].known);
        end
        for (int i = 0; i < 230; i++)
            send_word(random_segment(2, 2), 1'b0);
        in_ch.valid <= 1'b0;

        run_phase(0, 12800, 0, 768, 200, 3, 2);
        steady = 1'b1;
        run_phase(5120, 2560, 10240, 400, 200, 2, 1);
        steady = 1'b0;
        run_phase(300, 5000, 2000, 0, 150, 2, 2);
        run_phase(512, 0, 0, 768, 8, 0, 0);
        run_phase(2000, 9000, 1, 600, 40, 1, 0);
        run_phase(700, 4000, 3000, 512, 260, 2, 2);

        drain(200);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
